/* hw/rtl/kera_pkg.sv */
// Shared types and constants for the keyed event-rate anomaly detector.
package kera_pkg;

    localparam int KEY_W      = 64;
    localparam int COUNT_W    = 16;
    localparam int FIX_W      = 24;
    localparam int USED_OUT_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_EVENTS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 1'b1;

    localparam logic [COUNT_W-1:0] WINDOW_EVENTS_RST   = 16'd50;
    localparam logic [COUNT_W-1:0] SCORE_THRESHOLD_RST = 16'd768;
    localparam logic [COUNT_W-1:0] COUNT_SAT           = 16'hFFFF;

    // Q16.8 constants: 1.0 and 0.1 (rounded to nearest)
    localparam logic [FIX_W-1:0] Q_ONE     = 24'd256;
    localparam logic [FIX_W-1:0] Q_MIN_DEV = 24'd26;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] process_key;
    } item_t;

    typedef struct packed {
        logic                  status;
        logic                  anomalous;
        logic                  recalibrated;
        logic [USED_OUT_W-1:0] entries_used;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] window_events;
        logic [COUNT_W-1:0] score_threshold;
    } cfg_t;

    typedef struct packed {
        logic               calibrated;
        logic [COUNT_W-1:0] window_count;
        logic [FIX_W-1:0]   mean;
        logic [FIX_W-1:0]   deviation;
    } stat_t;

endpackage

/* hw/rtl/kera_queue.sv */
// Two-entry queue between the front end and the engine.
module kera_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kera_pkg::item_t push_data,
    input  logic           pop,
    output kera_pkg::item_t head,
    output logic           empty,
    output logic           full
);
    import kera_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* hw/rtl/kera_front.sv */
// Front end: takes transactions, masks the key and holds the configuration registers.
module kera_front #(
    parameter int KEY_BITS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  kera_pkg::item_t                       item,
    input  logic                                  cfg_we,
    input  logic [kera_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [kera_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  q_full,
    output logic                                  push,
    output kera_pkg::item_t                       push_data,
    output logic                                  busy,
    output kera_pkg::cfg_t                        cfg
);
    import kera_pkg::*;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

    cfg_t cfg_reg;

    assign busy                  = q_full;
    assign push                  = start && !q_full;
    assign push_data.command     = item.command;
    assign push_data.process_key = item.process_key & KEY_MASK;
    assign cfg                   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_events   <= WINDOW_EVENTS_RST;
            cfg_reg.score_threshold <= SCORE_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_EVENTS:   cfg_reg.window_events   <= cfg_data;
                CFG_SCORE_THRESHOLD: cfg_reg.score_threshold <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

endmodule

/* hw/rtl/kera_engine.sv */
// Engine: key search, record and query handling, and the recalibration walk.
module kera_engine #(
    parameter int MAX_ENTRIES = 1024,
    parameter int KEY_BITS    = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kera_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  kera_pkg::item_t   q_head,
    output logic              q_pop,
    output logic              done,
    output kera_pkg::result_t result
);
    import kera_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int UW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_ADD,
        S_STAT_RD,
        S_EXEC,
        S_QCMP,
        S_WALK_RD,
        S_WALK_MEAN,
        S_WALK_WR
    } state_t;

    logic [KEY_BITS-1:0] key_mem  [MAX_ENTRIES];
    stat_t               stat_mem [MAX_ENTRIES];

    state_t              state_reg;
    logic                cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [UW-1:0]       used_reg;
    logic [COUNT_W-1:0]  events_reg;
    logic [UW-1:0]       idx_reg;
    logic                cmp_v_reg;
    logic [AW-1:0]       cmp_idx_reg;
    logic [AW-1:0]       slot_reg;
    logic [KEY_BITS-1:0] key_rd_reg;
    stat_t               stat_rd_reg;
    logic [FIX_W-1:0]    c_reg;
    logic [FIX_W-1:0]    mean_new_reg;
    logic [39:0]         prod_reg;
    logic [31:0]         lhs_reg;
    logic                cal_reg;
    logic                done_reg;
    result_t             res_reg;

    logic                key_we;
    logic [AW-1:0]       key_wa;
    logic [AW-1:0]       key_ra;
    logic                stat_we;
    logic [AW-1:0]       stat_wa;
    stat_t               stat_wd;
    logic                stat_re;
    logic [AW-1:0]       stat_ra;

    logic                issue;
    logic                hit;
    logic                last_cmp;
    logic                table_full;
    logic [COUNT_W-1:0]  wc_inc;
    logic [COUNT_W-1:0]  ev_inc;
    logic [FIX_W-1:0]    c_cur;
    logic [FIX_W-1:0]    q_diff;
    logic [FIX_W-1:0]    w_diff;
    logic [FIX_W-1:0]    w_dev;
    stat_t               walk_word;

    assign done   = done_reg;
    assign result = res_reg;
    assign q_pop  = (state_reg == S_IDLE) && !q_empty;

    assign issue      = idx_reg < used_reg;
    assign hit        = cmp_v_reg && (key_rd_reg == key_reg);
    assign last_cmp   = cmp_v_reg && ((UW'(cmp_idx_reg) + UW'(1)) == used_reg);
    assign table_full = used_reg == UW'(MAX_ENTRIES);

    always_comb
    begin
        wc_inc = stat_rd_reg.window_count;
        if (wc_inc != COUNT_SAT)
        begin
            wc_inc = wc_inc + 16'd1;
        end
        ev_inc = events_reg;
        if (ev_inc != COUNT_SAT)
        begin
            ev_inc = ev_inc + 16'd1;
        end
        c_cur  = {stat_rd_reg.window_count, 8'b0};
        q_diff = (c_cur >= stat_rd_reg.mean) ? c_cur - stat_rd_reg.mean
                                             : stat_rd_reg.mean - c_cur;
        w_diff = (c_reg >= mean_new_reg) ? c_reg - mean_new_reg : mean_new_reg - c_reg;
        w_dev  = (w_diff < Q_MIN_DEV) ? Q_MIN_DEV : w_diff;
        walk_word.calibrated   = 1'b1;
        walk_word.window_count = '0;
        if (!stat_rd_reg.calibrated)
        begin
            walk_word.mean      = c_reg;
            walk_word.deviation = Q_ONE;
        end
        else
        begin
            walk_word.mean      = mean_new_reg;
            walk_word.deviation = w_dev;
        end
    end

    // Memory port control
    always_comb
    begin
        key_we  = 1'b0;
        key_wa  = used_reg[AW-1:0];
        key_ra  = idx_reg[AW-1:0];
        stat_we = 1'b0;
        stat_wa = slot_reg;
        stat_wd = stat_rd_reg;
        stat_re = 1'b0;
        stat_ra = slot_reg;
        case (state_reg)
            S_ADD:
            begin
                if (!table_full)
                begin
                    key_we  = 1'b1;
                    stat_we = 1'b1;
                    stat_wa = used_reg[AW-1:0];
                    stat_wd = '0;
                end
            end
            S_STAT_RD:
            begin
                stat_re = 1'b1;
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_RECORD)
                begin
                    stat_we              = 1'b1;
                    stat_wd.window_count = wc_inc;
                end
            end
            S_WALK_RD:
            begin
                stat_re = issue;
                stat_ra = idx_reg[AW-1:0];
            end
            S_WALK_WR:
            begin
                stat_we = 1'b1;
                stat_wa = idx_reg[AW-1:0];
                stat_wd = walk_word;
            end
            default:
            begin
                stat_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_reg;
        end
        key_rd_reg <= key_mem[key_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_wa] <= stat_wd;
        end
        if (stat_re)
        begin
            stat_rd_reg <= stat_mem[stat_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= CMD_RECORD;
            key_reg      <= '0;
            used_reg     <= '0;
            events_reg   <= '0;
            idx_reg      <= '0;
            cmp_v_reg    <= 1'b0;
            cmp_idx_reg  <= '0;
            slot_reg     <= '0;
            c_reg        <= '0;
            mean_new_reg <= '0;
            prod_reg     <= '0;
            lhs_reg      <= '0;
            cal_reg      <= 1'b0;
            done_reg     <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg   <= q_head.command;
                        key_reg   <= q_head.process_key[KEY_BITS-1:0];
                        idx_reg   <= '0;
                        cmp_v_reg <= 1'b0;
                        state_reg <= (used_reg == '0) ? S_ADD : S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    // Stream reads one entry a cycle; each compare happens in the cycle after its read
                    cmp_v_reg   <= issue;
                    cmp_idx_reg <= idx_reg[AW-1:0];
                    if (issue)
                    begin
                        idx_reg <= idx_reg + UW'(1);
                    end
                    if (hit)
                    begin
                        slot_reg  <= cmp_idx_reg;
                        state_reg <= S_STAT_RD;
                    end
                    else if (last_cmp)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    if (table_full)
                    begin
                        done_reg             <= 1'b1;
                        res_reg.status       <= 1'b1;
                        res_reg.anomalous    <= 1'b0;
                        res_reg.recalibrated <= 1'b0;
                        res_reg.entries_used <= USED_OUT_W'(used_reg);
                        state_reg            <= S_IDLE;
                    end
                    else
                    begin
                        slot_reg  <= used_reg[AW-1:0];
                        used_reg  <= used_reg + UW'(1);
                        state_reg <= S_STAT_RD;
                    end
                end
                S_STAT_RD:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (cmd_reg == CMD_RECORD)
                    begin
                        events_reg <= ev_inc;
                        if (ev_inc >= cfg.window_events)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_WALK_RD;
                        end
                        else
                        begin
                            done_reg             <= 1'b1;
                            res_reg.status       <= 1'b0;
                            res_reg.anomalous    <= 1'b0;
                            res_reg.recalibrated <= 1'b0;
                            res_reg.entries_used <= USED_OUT_W'(used_reg);
                            state_reg            <= S_IDLE;
                        end
                    end
                    else
                    begin
                        cal_reg   <= stat_rd_reg.calibrated;
                        lhs_reg   <= {q_diff, 8'b0};
                        prod_reg  <= 40'(cfg.score_threshold) * 40'(stat_rd_reg.deviation);
                        state_reg <= S_QCMP;
                    end
                end
                S_QCMP:
                begin
                    done_reg             <= 1'b1;
                    res_reg.status       <= 1'b0;
                    res_reg.anomalous    <= cal_reg && (40'(lhs_reg) > prod_reg);
                    res_reg.recalibrated <= 1'b0;
                    res_reg.entries_used <= USED_OUT_W'(used_reg);
                    state_reg            <= S_IDLE;
                end
                S_WALK_RD:
                begin
                    if (issue)
                    begin
                        state_reg <= S_WALK_MEAN;
                    end
                    else
                    begin
                        events_reg           <= '0;
                        done_reg             <= 1'b1;
                        res_reg.status       <= 1'b0;
                        res_reg.anomalous    <= 1'b0;
                        res_reg.recalibrated <= 1'b1;
                        res_reg.entries_used <= USED_OUT_W'(used_reg);
                        state_reg            <= S_IDLE;
                    end
                end
                S_WALK_MEAN:
                begin
                    c_reg        <= {stat_rd_reg.window_count, 8'b0};
                    mean_new_reg <= FIX_W'((25'(stat_rd_reg.mean)
                                    + 25'({stat_rd_reg.window_count, 8'b0})) >> 1);
                    state_reg    <= S_WALK_WR;
                end
                S_WALK_WR:
                begin
                    idx_reg   <= idx_reg + UW'(1);
                    state_reg <= S_WALK_RD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/keyed_event_rate_anomaly_detector.sv */
// Top level of the keyed event-rate anomaly detector.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------
//  input     | start / busy       | item   (command, process_key)
//  result    | done (one cycle)   | result (status, anomalous, recalibrated,
//            |                    |         entries_used)
//  config    | cfg_we             | cfg_index, cfg_data
//
// The key search reads one table entry a cycle. When a record closes a window, the walk
// recalibrates every occupied entry through the single statistics port.
// A two-entry queue takes up to two further transactions while the engine works.
// Reset empties the table at once; no clearing pass is run.
// The receiver cannot stall: each result is shown on done for exactly one cycle.
module keyed_event_rate_anomaly_detector #(
    parameter int MAX_ENTRIES = 1024,
    parameter int KEY_BITS    = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  kera_pkg::item_t                 item,
    output logic                            done,
    output kera_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [kera_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kera_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kera_pkg::*;

    logic  push;
    item_t push_data;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    item_t q_head;
    cfg_t  cfg;

    kera_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data),
        .busy      (busy),
        .cfg       (cfg)
    );

    kera_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    kera_engine #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

endmodule

/* hw/rtl/kera_checker.sv */
// Port-level checks for the anomaly detector, bound to the top level.
module kera_checker #(
    parameter int MAX_ENTRIES = 1024
) (
    input logic              clk,
    input logic              rst_n,
    input logic              done,
    input kera_pkg::result_t result
);
    import kera_pkg::*;

    // Every transaction needs a search or an add before its result
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on consecutive cycles");

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (!result.anomalous && !result.recalibrated))
        else $error("dropped transaction carries a flag");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.entries_used == USED_OUT_W'(MAX_ENTRIES)))
        else $error("drop while the table has room");

    a_recal_not_query: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.recalibrated) |-> !result.anomalous)
        else $error("recalibration and anomaly in one result");

endmodule

bind keyed_event_rate_anomaly_detector kera_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_kera_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .done   (done),
    .result (result)
);

/* tb/keyed_event_rate_anomaly_detector_tb.sv */
// Self-checking testbench for the keyed event-rate anomaly detector.
`timescale 1ns / 1ps

module keyed_event_rate_anomaly_detector_tb;
    import kera_pkg::*;

    localparam int ENTRIES        = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 4200;
    localparam int PHASE_ITEMS    = 120;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    item_t                 item = '0;
    logic                  done;
    result_t               result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the detector table and registers
    logic [KEY_W-1:0]   key_tbl [ENTRIES];
    logic [COUNT_W-1:0] win_cnt [ENTRIES];
    logic [FIX_W-1:0]   mean_q [ENTRIES];
    logic [FIX_W-1:0]   dev_q [ENTRIES];
    logic               calib [ENTRIES];
    int                 used_cnt = 0;
    logic [COUNT_W-1:0] event_total = '0;
    logic [COUNT_W-1:0] window_cfg = WINDOW_EVENTS_RST;
    logic [COUNT_W-1:0] threshold_cfg = SCORE_THRESHOLD_RST;

    result_t          pending_results[$];
    logic [KEY_W-1:0] key_pool[$];
    int               mismatches = 0;
    int               idle_cycles = 0;
    int               burst_left = 4;
    bit               start_high = 0;

    always #5 clk = ~clk;

    keyed_event_rate_anomaly_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic result_t predict_detector(input logic cmd, input logic [KEY_W-1:0] key);
        result_t          r;
        int               slot;
        logic [FIX_W-1:0] c;
        logic [FIX_W:0]   sum;
        logic [FIX_W-1:0] m;
        logic [FIX_W-1:0] d;
        logic [63:0]      lhs;
        logic [63:0]      rhs;
        r = '0;
        slot = -1;
        for (int i = 0; i < used_cnt && slot < 0; i++)
            if (key_tbl[i] == key)
                slot = i;
        if (slot < 0 && used_cnt < ENTRIES)
        begin
            key_tbl[used_cnt] = key;
            win_cnt[used_cnt] = '0;
            slot = used_cnt;
            used_cnt++;
        end
        if (slot < 0)
            r.status = 1'b1;
        else if (cmd == CMD_RECORD)
        begin
            if (win_cnt[slot] != COUNT_SAT)
                win_cnt[slot]++;
            if (event_total != COUNT_SAT)
                event_total++;
            if (event_total >= window_cfg)
            begin
                // walk every occupied entry
                for (int i = 0; i < used_cnt; i++)
                begin
                    c = {win_cnt[i], 8'd0};
                    if (!calib[i])
                    begin
                        mean_q[i] = c;
                        dev_q[i]  = Q_ONE;
                        calib[i]  = 1'b1;
                    end
                    else
                    begin
                        sum = {1'b0, mean_q[i]} + {1'b0, c};
                        m = sum[FIX_W:1];
                        d = (c >= m) ? c - m : m - c;
                        mean_q[i] = m;
                        dev_q[i]  = (d < Q_MIN_DEV) ? Q_MIN_DEV : d;
                    end
                    win_cnt[i] = '0;
                end
                event_total = '0;
                r.recalibrated = 1'b1;
            end
        end
        else if (calib[slot])
        begin
            c = {win_cnt[slot], 8'd0};
            d = (c >= mean_q[slot]) ? c - mean_q[slot] : mean_q[slot] - c;
            lhs = {32'd0, d, 8'd0};
            rhs = 64'(threshold_cfg) * 64'(dev_q[slot]);
            r.anomalous = (lhs > rhs);
        end
        r.entries_used = used_cnt[USED_OUT_W-1:0];
        return r;
    endfunction

    // one transaction; start stays high across a burst
    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key);
        item  <= {cmd, key};
        start <= 1'b1;
        start_high = 1;
        do @(posedge clk); while (busy);
        pending_results.push_back(predict_detector(cmd, key));
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                start_high = 0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        if (start_high)
        begin
            start <= 1'b0;
            start_high = 0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_WINDOW_EVENTS)
            window_cfg = val;
        else
            threshold_cfg = val;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        send_item(CMD_RECORD, 64'h0);
        send_item(CMD_RECORD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(CMD_QUERY, 64'h5555_5555_5555_5555);
        send_item(CMD_QUERY, 64'h0);
        // zero window: every record recalibrates
        write_reg(CFG_WINDOW_EVENTS, 16'd0);
        send_item(CMD_RECORD, 64'h0);
        send_item(CMD_RECORD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_QUERY, 64'h0);
        write_reg(CFG_WINDOW_EVENTS, 16'hFFFF);
        write_reg(CFG_SCORE_THRESHOLD, 16'd0);
        send_item(CMD_RECORD, 64'h0);
        send_item(CMD_RECORD, 64'h0);
        send_item(CMD_QUERY, 64'h0);
        send_item(CMD_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
        write_reg(CFG_SCORE_THRESHOLD, 16'hFFFF);
        send_item(CMD_QUERY, 64'h0);
        write_reg(CFG_WINDOW_EVENTS, 16'd1);
        send_item(CMD_RECORD, 64'h5555_5555_5555_5555);
        send_item(CMD_QUERY, 64'h5555_5555_5555_5555);
        send_item(CMD_RECORD, 64'h1);
    endtask

    task automatic test_random_phases();
        logic [COUNT_W-1:0] windows [8];
        logic [COUNT_W-1:0] thresholds [8];
        logic [KEY_W-1:0]   hot;
        logic [KEY_W-1:0]   k;
        int                 pick;
        windows    = '{16'd50, 16'd1, 16'd2, 16'd7, 16'hFFFF, 16'd0, 16'd3, 16'd0};
        thresholds = '{16'd768, 16'd0, 16'd256, 16'd512, 16'hFFFF, 16'd0, 16'd128, 16'd0};
        windows[5]    = COUNT_W'($urandom_range(4, 40));
        thresholds[5] = COUNT_W'($urandom());
        windows[7]    = COUNT_W'($urandom_range(8, 120));
        thresholds[7] = COUNT_W'($urandom_range(0, 1024));
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_WINDOW_EVENTS, windows[p]);
            write_reg(CFG_SCORE_THRESHOLD, thresholds[p]);
            // keep a few keys from the last phase, add fresh ones
            while (key_pool.size() > 4)
                void'(key_pool.pop_front());
            repeat (12) key_pool.push_back(random_key());
            hot = key_pool[$urandom_range(0, key_pool.size() - 1)];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    hot = key_pool[$urandom_range(0, key_pool.size() - 1)];
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    k = random_key();
                else if (pick < 45)
                    k = hot;
                else
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                send_item(($urandom_range(0, 99) < 35) ? CMD_QUERY : CMD_RECORD, k);
            end
        end
    endtask

    task automatic test_full_table();
        logic [KEY_W-1:0] k;
        write_reg(CFG_WINDOW_EVENTS, 16'hFFFF);
        while (used_cnt < ENTRIES)
        begin
            k = random_key();
            key_pool.push_back(k);
            send_item(CMD_RECORD, k);
        end
        write_reg(CFG_WINDOW_EVENTS, 16'd4);
        write_reg(CFG_SCORE_THRESHOLD, 16'd300);
        // new keys are dropped now; known keys still work
        repeat (80)
        begin
            if ($urandom_range(0, 99) < 40)
                k = random_key();
            else
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_item($urandom_range(0, 1) ? CMD_QUERY : CMD_RECORD, k);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d anomalous=%0d recal=%0d used=%0d",
                             result.status, result.anomalous, result.recalibrated,
                             result.entries_used);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status !== result.status || want.anomalous !== result.anomalous ||
                    want.recalibrated !== result.recalibrated ||
                    want.entries_used !== result.entries_used)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp s=%0d a=%0d r=%0d u=%0d got s=%0d a=%0d r=%0d u=%0d",
                                 want.status, want.anomalous, want.recalibrated,
                                 want.entries_used, result.status, result.anomalous,
                                 result.recalibrated, result.entries_used);
                end
            end
        end
    end

    // abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("keyed_event_rate_anomaly_detector_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_tbl[i] = '0;
            win_cnt[i] = '0;
            mean_q[i]  = '0;
            dev_q[i]   = '0;
            calib[i]   = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_full_table();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("keyed_event_rate_anomaly_detector_tb OK");
        else
            $display("keyed_event_rate_anomaly_detector_tb NOT OK");
        $finish;
    end

endmodule

/* keyed_event_rate_anomaly_detector.f */
hw/rtl/kera_pkg.sv
hw/rtl/kera_queue.sv
hw/rtl/kera_front.sv
hw/rtl/kera_engine.sv
hw/rtl/keyed_event_rate_anomaly_detector.sv
hw/rtl/kera_checker.sv
tb/keyed_event_rate_anomaly_detector_tb.sv
